// File: rtl/abs_pkg.sv
// ----------------------------------------------------------------------------
// abs_pkg: shared types and constants of the adaptive bitrate selector
// Configuration record, compare-unit flag bundle and register index codes.
// ----------------------------------------------------------------------------
package abs_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_IDX_W = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RATE_MIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_MAX      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_BUFFER    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_BUFFER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_HOLD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RAMPUP        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_START_SECONDS = 3'd7;

    // register reset values
    localparam logic [30:0] RST_RATE_MIN      = 31'd0;
    localparam logic [30:0] RST_RATE_MAX      = 31'h7FFF_FFFF;
    localparam logic [4:0]  RST_TABLE_SIZE    = 5'd16;
    localparam logic [19:0] RST_LOW_BUFFER    = 20'd5000;
    localparam logic [19:0] RST_NORMAL_BUFFER = 20'd20000;
    localparam logic [15:0] RST_SWITCH_HOLD   = 16'd15;
    localparam logic [15:0] RST_RAMPUP        = 16'd20;
    localparam logic [31:0] RST_START_SECONDS = 32'd0;

    typedef struct packed {
        logic [30:0] rate_min;
        logic [30:0] rate_max;
        logic [4:0]  table_size;
        logic [19:0] low_buffer_ms;
        logic [19:0] normal_buffer_ms;
        logic [15:0] switch_up_hold_s;
        logic [15:0] rampup_s;
        logic [31:0] start_seconds;
    } cfg_t;

    // per-entry compare results
    typedef struct packed {
        logic fit;      // 5*entry <= 4*throughput
        logic gt_min;   // entry >  rate_min
        logic lt_min;   // entry <  rate_min
        logic lt_max;   // entry <  rate_max
        logic gt_max;   // entry >  rate_max
        logic eq_rate;  // entry == current bitrate
    } cmp_flags_t;

endpackage

// File: rtl/abs_table.sv
// ----------------------------------------------------------------------------
// abs_table: bitrate table storage
// Single write port, one registered read port.
// ----------------------------------------------------------------------------
module abs_table #(
    parameter int DEPTH = 16,
    localparam int IDXW = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [IDXW-1:0]             wr_addr,
    input  logic [abs_pkg::DATA_W-1:0]  wr_data,
    input  logic [IDXW-1:0]             rd_addr,
    output logic [abs_pkg::DATA_W-1:0]  rd_data
);

    logic [abs_pkg::DATA_W-1:0] mem [DEPTH];
    logic [abs_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/abs_cmp.sv
// ----------------------------------------------------------------------------
// abs_cmp: shared entry compare unit
// Tests one table entry against throughput, rate window and current rate.
// ----------------------------------------------------------------------------
module abs_cmp (
    input  logic [abs_pkg::DATA_W-1:0] entry,
    input  logic [abs_pkg::DATA_W-1:0] tp,
    input  logic [abs_pkg::DATA_W-1:0] rate,
    input  abs_pkg::cfg_t              cfg,
    output abs_pkg::cmp_flags_t        flags
);

    logic [34:0] five_b;
    logic [34:0] four_t;
    logic [31:0] min_ext;
    logic [31:0] max_ext;

    // 0.8 slack done exactly: 5*b <= 4*t
    assign five_b  = {1'b0, entry, 2'b00} + {3'b000, entry};
    assign four_t  = {1'b0, tp, 2'b00};
    assign min_ext = {1'b0, cfg.rate_min};
    assign max_ext = {1'b0, cfg.rate_max};

    always_comb
    begin
        flags.fit     = (five_b <= four_t);
        flags.gt_min  = (entry > min_ext);
        flags.lt_min  = (entry < min_ext);
        flags.lt_max  = (entry < max_ext);
        flags.gt_max  = (entry > max_ext);
        flags.eq_rate = (entry == rate);
    end

endmodule

// File: rtl/abs_seq.sv
// ----------------------------------------------------------------------------
// abs_seq: decision sequencer
// Walks the table one entry per cycle through the shared compare unit and
// runs the buffer-band rules; also owns the hold timer and result registers.
// ----------------------------------------------------------------------------
module abs_seq #(
    parameter int TABLE_DEPTH = 16,
    localparam int IDXW = $clog2(TABLE_DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    output logic                        done,
    input  logic                        mode,
    input  logic [3:0]                  entry_index,
    input  logic [31:0]                 entry_bitrate,
    input  logic [31:0]                 last_throughput,
    input  logic [31:0]                 avg_throughput,
    input  logic [19:0]                 buffer_ms,
    input  logic [31:0]                 current_bitrate,
    input  logic [31:0]                 now_seconds,
    input  abs_pkg::cfg_t               cfg,
    output logic                        tbl_wr_en,
    output logic [IDXW-1:0]             tbl_wr_addr,
    output logic [abs_pkg::DATA_W-1:0]  tbl_wr_data,
    output logic [IDXW-1:0]             tbl_rd_addr,
    output logic [abs_pkg::DATA_W-1:0]  cmp_tp,
    output logic [abs_pkg::DATA_W-1:0]  cmp_rate,
    input  abs_pkg::cmp_flags_t         flags,
    output logic [IDXW-1:0]             res_index,
    output logic                        res_error,
    output logic                        res_up
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_UP   = 5'b00100,
        ST_DOWN = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        PH_LOW      = 2'd0,
        PH_IDX      = 2'd1,
        PH_FIT_AVG  = 2'd2,
        PH_FIT_LAST = 2'd3
    } phase_t;

    localparam logic [IDXW-1:0] IDX_ZERO = '0;
    localparam logic [IDXW-1:0] IDX_ONE  = IDXW'(1);

    state_t          state_reg, state_next;
    phase_t          phase_reg, phase_next;
    logic [IDXW-1:0] addr_reg, addr_next;
    logic [IDXW-1:0] cur_reg, cur_next;
    logic [IDXW-1:0] cand_reg, cand_next;
    logic [IDXW-1:0] res_reg, res_next;
    logic            err_reg, err_next;
    logic            up_reg, up_next;
    logic            high_reg, high_next;
    logic            prev_lt_max_reg, prev_lt_max_next;
    logic            time_ok_reg;
    logic [31:0]     last_inc_reg, last_inc_next;
    logic [31:0]     tp_last_reg, tp_last_next;
    logic [31:0]     tp_avg_reg, tp_avg_next;
    logic [31:0]     cur_rate_reg, cur_rate_next;
    logic [31:0]     now_reg, now_next;

    logic [IDXW-1:0] last_idx;
    logic            hit;
    logic [IDXW-1:0] fit_found;
    logic [32:0]     since_diff;
    logic [32:0]     play_diff;
    logic            hold_ok;
    logic            ramp_ok;

    // effective last index: size 0 acts as 1, oversize clamps to depth
    always_comb
    begin
        if (cfg.table_size == 5'd0)
        begin
            last_idx = IDX_ZERO;
        end
        else if (32'(cfg.table_size) > TABLE_DEPTH)
        begin
            last_idx = IDXW'(TABLE_DEPTH - 1);
        end
        else
        begin
            last_idx = IDXW'(cfg.table_size - 5'd1);
        end
    end

    assign hit       = flags.fit && flags.gt_min && flags.lt_max;
    assign fit_found = hit ? addr_reg : IDX_ZERO;

    // signed time differences, 33 bits
    assign since_diff = {1'b0, now_reg} - {1'b0, last_inc_reg};
    assign play_diff  = {1'b0, now_reg} - {1'b0, cfg.start_seconds};
    assign hold_ok    = !since_diff[32] && (since_diff[31:0] >= {16'd0, cfg.switch_up_hold_s});
    assign ramp_ok    = play_diff[32] || (play_diff[31:0] < {16'd0, cfg.rampup_s});

    assign cmp_tp   = (phase_reg == PH_FIT_AVG) ? tp_avg_reg : tp_last_reg;
    assign cmp_rate = cur_rate_reg;

    assign tbl_wr_addr = IDXW'(entry_index);
    assign tbl_wr_data = entry_bitrate;
    assign tbl_rd_addr = addr_next;

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        addr_next        = addr_reg;
        cur_next         = cur_reg;
        cand_next        = cand_reg;
        res_next         = res_reg;
        err_next         = err_reg;
        up_next          = up_reg;
        high_next        = high_reg;
        prev_lt_max_next = prev_lt_max_reg;
        last_inc_next    = last_inc_reg;
        tp_last_next     = tp_last_reg;
        tp_avg_next      = tp_avg_reg;
        cur_rate_next    = cur_rate_reg;
        now_next         = now_reg;
        tbl_wr_en        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    res_next = IDX_ZERO;
                    err_next = 1'b0;
                    up_next  = 1'b0;
                    if (!mode)
                    begin
                        tbl_wr_en  = (32'(entry_index) < TABLE_DEPTH);
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        tp_last_next  = last_throughput;
                        tp_avg_next   = avg_throughput;
                        cur_rate_next = current_bitrate;
                        now_next      = now_seconds;
                        high_next     = (buffer_ms >= cfg.normal_buffer_ms);
                        if (cfg.rate_min > cfg.rate_max)
                        begin
                            err_next   = 1'b1;
                            state_next = ST_DONE;
                        end
                        // panic band only below both marks; the high band wins
                        else if ((last_throughput == 32'd0) ||
                                 ((buffer_ms < cfg.low_buffer_ms) &&
                                  (buffer_ms < cfg.normal_buffer_ms)))
                        begin
                            phase_next = PH_LOW;
                            addr_next  = last_idx;
                            state_next = ST_SCAN;
                        end
                        else
                        begin
                            phase_next = PH_IDX;
                            addr_next  = last_idx;
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                case (phase_reg)
                    PH_IDX:
                    begin
                        if (flags.eq_rate || (addr_reg == IDX_ZERO))
                        begin
                            cur_next   = flags.eq_rate ? addr_reg : IDX_ZERO;
                            phase_next = high_reg ? PH_FIT_AVG : PH_FIT_LAST;
                            addr_next  = last_idx;
                        end
                        else
                        begin
                            addr_next = addr_reg - IDX_ONE;
                        end
                    end

                    PH_FIT_AVG:
                    begin
                        if (hit || (addr_reg == IDX_ZERO))
                        begin
                            if (fit_found > cur_reg)
                            begin
                                phase_next = PH_FIT_LAST;
                                addr_next  = last_idx;
                            end
                            else
                            begin
                                res_next   = cur_reg;
                                state_next = ST_DONE;
                            end
                        end
                        else
                        begin
                            addr_next = addr_reg - IDX_ONE;
                        end
                    end

                    PH_FIT_LAST:
                    begin
                        if (hit || (addr_reg == IDX_ZERO))
                        begin
                            cand_next = fit_found;
                            if ((fit_found > cur_reg) && (!high_reg || time_ok_reg))
                            begin
                                addr_next  = cur_reg + IDX_ONE;
                                state_next = ST_UP;
                            end
                            else if ((fit_found < cur_reg) && !high_reg)
                            begin
                                addr_next  = cur_reg - IDX_ONE;
                                state_next = ST_DOWN;
                            end
                            else
                            begin
                                res_next   = cur_reg;
                                state_next = ST_DONE;
                            end
                        end
                        else
                        begin
                            addr_next = addr_reg - IDX_ONE;
                        end
                    end

                    PH_LOW:
                    begin
                        // pair (addr+1, addr): upper below max, lower below min
                        prev_lt_max_next = flags.lt_max;
                        if ((addr_reg != last_idx) && prev_lt_max_reg && flags.lt_min)
                        begin
                            res_next   = addr_reg + IDX_ONE;
                            state_next = ST_DONE;
                        end
                        else if (addr_reg == IDX_ZERO)
                        begin
                            res_next   = IDX_ZERO;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            addr_next = addr_reg - IDX_ONE;
                        end
                    end

                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_UP:
            begin
                // entry above current one
                if (flags.gt_max)
                begin
                    res_next = cur_reg;
                end
                else if (flags.lt_min)
                begin
                    res_next = cand_reg;
                end
                else
                begin
                    res_next      = cur_reg + IDX_ONE;
                    up_next       = 1'b1;
                    last_inc_next = now_reg;
                end
                state_next = ST_DONE;
            end

            ST_DOWN:
            begin
                res_next   = flags.lt_min ? cur_reg : (cur_reg - IDX_ONE);
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= PH_LOW;
            err_reg         <= 1'b0;
            up_reg          <= 1'b0;
            res_reg         <= IDX_ZERO;
            last_inc_reg    <= 32'd0;
            time_ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            err_reg         <= err_next;
            up_reg          <= up_next;
            res_reg         <= res_next;
            last_inc_reg    <= last_inc_next;
            time_ok_reg     <= hold_ok || ramp_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg        <= addr_next;
        cur_reg         <= cur_next;
        cand_reg        <= cand_next;
        high_reg        <= high_next;
        prev_lt_max_reg <= prev_lt_max_next;
        tp_last_reg     <= tp_last_next;
        tp_avg_reg      <= tp_avg_next;
        cur_rate_reg    <= cur_rate_next;
        now_reg         <= now_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = (state_reg == ST_DONE);
    assign res_index = res_reg;
    assign res_error = err_reg;
    assign res_up    = up_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after result");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && err_reg) |-> (!up_reg && (res_reg == IDX_ZERO)))
        else $error("range error result carries index or step-up");

    a_up_timer: assert property (@(posedge clk) disable iff (!rst_n)
        (done && up_reg) |-> (last_inc_reg == now_reg))
        else $error("step-up without hold timer restart");

endmodule

// File: rtl/adaptive_bitrate_selector.sv
// ----------------------------------------------------------------------------
// adaptive_bitrate_selector: next-bitrate chooser over an ascending rate table
// Timing: a load item shows its result in the cycle after acceptance; a decision
//   item walks one table entry per cycle through the single compare unit, over
//   the table entries in use, three scans worst case.
// Throughput: one item at a time, loads and decisions alike; busy stays high
//   until the result strobe has gone out.
// Reset (rst_n low, async): sequencer idle, hold timer zero, config registers
//   at defaults; table contents undefined until loaded. Results cannot stall.
// ----------------------------------------------------------------------------
module adaptive_bitrate_selector #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // item handshake
    input  logic                            start,
    output logic                            busy,
    output logic                            done,
    // input item
    input  logic                            mode,
    input  logic [3:0]                      entry_index,
    input  logic [31:0]                     entry_bitrate,
    input  logic [31:0]                     last_throughput,
    input  logic [31:0]                     avg_throughput,
    input  logic [19:0]                     buffer_ms,
    input  logic [31:0]                     current_bitrate,
    input  logic [31:0]                     now_seconds,
    // result item
    output logic [3:0]                      new_index,
    output logic                            range_error,
    output logic                            stepped_up,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [abs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [abs_pkg::DATA_W-1:0]      cfg_wdata
);

    localparam int IDXW = $clog2(TABLE_DEPTH);

    abs_pkg::cfg_t              cfg_reg;
    abs_pkg::cmp_flags_t        flags;

    logic                       tbl_wr_en;
    logic [IDXW-1:0]            tbl_wr_addr;
    logic [abs_pkg::DATA_W-1:0] tbl_wr_data;
    logic [IDXW-1:0]            tbl_rd_addr;
    logic [abs_pkg::DATA_W-1:0] tbl_rd_data;
    logic [abs_pkg::DATA_W-1:0] cmp_tp;
    logic [abs_pkg::DATA_W-1:0] cmp_rate;
    logic [IDXW-1:0]            res_index;

    // Configuration registers. The user must write them only while idle, so no shadowing; not enforced here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate_min         <= abs_pkg::RST_RATE_MIN;
            cfg_reg.rate_max         <= abs_pkg::RST_RATE_MAX;
            cfg_reg.table_size       <= abs_pkg::RST_TABLE_SIZE;
            cfg_reg.low_buffer_ms    <= abs_pkg::RST_LOW_BUFFER;
            cfg_reg.normal_buffer_ms <= abs_pkg::RST_NORMAL_BUFFER;
            cfg_reg.switch_up_hold_s <= abs_pkg::RST_SWITCH_HOLD;
            cfg_reg.rampup_s         <= abs_pkg::RST_RAMPUP;
            cfg_reg.start_seconds    <= abs_pkg::RST_START_SECONDS;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                abs_pkg::REG_RATE_MIN:      cfg_reg.rate_min         <= cfg_wdata[30:0];
                abs_pkg::REG_RATE_MAX:      cfg_reg.rate_max         <= cfg_wdata[30:0];
                abs_pkg::REG_TABLE_SIZE:    cfg_reg.table_size       <= cfg_wdata[4:0];
                abs_pkg::REG_LOW_BUFFER:    cfg_reg.low_buffer_ms    <= cfg_wdata[19:0];
                abs_pkg::REG_NORMAL_BUFFER: cfg_reg.normal_buffer_ms <= cfg_wdata[19:0];
                abs_pkg::REG_SWITCH_HOLD:   cfg_reg.switch_up_hold_s <= cfg_wdata[15:0];
                abs_pkg::REG_RAMPUP:        cfg_reg.rampup_s         <= cfg_wdata[15:0];
                abs_pkg::REG_START_SECONDS: cfg_reg.start_seconds    <= cfg_wdata;
                default:                    cfg_reg.start_seconds    <= cfg_reg.start_seconds;
            endcase
        end
    end

    // Table: write on load items, read address driven ahead by the sequencer
    // so the entry under test is ready the next cycle.
    abs_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    // One compare unit shared by every scan and single-entry check.
    abs_cmp u_cmp (
        .entry (tbl_rd_data),
        .tp    (cmp_tp),
        .rate  (cmp_rate),
        .cfg   (cfg_reg),
        .flags (flags)
    );

    // Sequencer: index lookup, throughput fits, lowest-in-window and the
    // one-step up/down checks, plus the hold timer.
    abs_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .done            (done),
        .mode            (mode),
        .entry_index     (entry_index),
        .entry_bitrate   (entry_bitrate),
        .last_throughput (last_throughput),
        .avg_throughput  (avg_throughput),
        .buffer_ms       (buffer_ms),
        .current_bitrate (current_bitrate),
        .now_seconds     (now_seconds),
        .cfg             (cfg_reg),
        .tbl_wr_en       (tbl_wr_en),
        .tbl_wr_addr     (tbl_wr_addr),
        .tbl_wr_data     (tbl_wr_data),
        .tbl_rd_addr     (tbl_rd_addr),
        .cmp_tp          (cmp_tp),
        .cmp_rate        (cmp_rate),
        .flags           (flags),
        .res_index       (res_index),
        .res_error       (range_error),
        .res_up          (stepped_up)
    );

    // result index is reported in four bits
    assign new_index = abs_pkg::OUT_IDX_W'(res_index);

endmodule

// File: bench/tb_adaptive_bitrate_selector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_adaptive_bitrate_selector: self-checking bench for the bitrate selector
// Loads ascending rate tables and sends decision items through the start/busy
// handshake. A local predictor computes each expected index and flag. Every
// done strobe is checked against it, across several register settings.
// ----------------------------------------------------------------------------
module tb_adaptive_bitrate_selector;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    // margin after the last result
    localparam int DRAIN       = 60;
    localparam int PHASES      = 9;

    // one input item as it appears on the ports
    typedef struct packed {
        logic        mode;
        logic [3:0]  entry_index;
        logic [31:0] entry_bitrate;
        logic [31:0] last_tp;
        logic [31:0] avg_tp;
        logic [19:0] buffer_lvl;
        logic [31:0] cur_rate;
        logic [31:0] now_s;
    } abr_item_t;

    // one result item
    typedef struct packed {
        logic [3:0] idx;
        logic       err;
        logic       up;
    } abr_choice_t;

    logic        clk;
    logic        rst_n           = 1'b0;
    logic        start           = 1'b0;
    logic        mode            = 1'b0;
    logic [3:0]  entry_index     = '0;
    logic [31:0] entry_bitrate   = '0;
    logic [31:0] last_throughput = '0;
    logic [31:0] avg_throughput  = '0;
    logic [19:0] buffer_ms       = '0;
    logic [31:0] current_bitrate = '0;
    logic [31:0] now_seconds     = '0;
    logic                          cfg_wr_en = 1'b0;
    logic [abs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [abs_pkg::DATA_W-1:0]    cfg_wdata = '0;

    logic        busy;
    logic        done;
    logic [3:0]  new_index;
    logic        range_error;
    logic        stepped_up;

    adaptive_bitrate_selector #(
        .TABLE_DEPTH (DEPTH)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .done            (done),
        .mode            (mode),
        .entry_index     (entry_index),
        .entry_bitrate   (entry_bitrate),
        .last_throughput (last_throughput),
        .avg_throughput  (avg_throughput),
        .buffer_ms       (buffer_ms),
        .current_bitrate (current_bitrate),
        .now_seconds     (now_seconds),
        .new_index       (new_index),
        .range_error     (range_error),
        .stepped_up      (stepped_up),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the rate table, hold timer and
    // registers, updated only from what is seen on the ports.
    // ------------------------------------------------------------------
    logic [31:0]   pred_tbl [DEPTH];
    logic [31:0]   pred_last_up;
    abs_pkg::cfg_t pred_cfg;
    abr_choice_t   choice_q [$];

    int errors      = 0;
    int n_loads     = 0;
    int n_decisions = 0;
    int n_steps     = 0;
    int n_range_err = 0;
    int n_settings  = 1;
    int unsigned taken_cnt = 0;

    // table_size 0 behaves as 1, anything past the depth as the depth
    function automatic int used_entries();
        int n;
        n = int'(pred_cfg.table_size);
        if (n == 0)
            n = 1;
        if (n > DEPTH)
            n = DEPTH;
        return n;
    endfunction

    // highest entry with 5*rate <= 4*tp, strictly inside the window; else 0
    function automatic int best_fit(logic [31:0] tp, int n);
        int i;
        for (i = n - 1; i >= 0; i--)
            if (({32'd0, pred_tbl[i]} * 64'd5 <= {32'd0, tp} * 64'd4) &&
                pred_tbl[i] > pred_cfg.rate_min && pred_tbl[i] < pred_cfg.rate_max)
                return i;
        return 0;
    endfunction

    // lowest entry still inside the window, scanning down from the top
    function automatic int lowest_in_window(int n);
        int i;
        for (i = n - 1; i > 0; i--)
            if (pred_tbl[i] < pred_cfg.rate_max)
            begin
                if (pred_tbl[i-1] < pred_cfg.rate_min)
                    return i;
                if (i == 1)
                    return 0;
            end
        return 0;
    endfunction

    // position of the playing rate; unknown rates count as index 0
    function automatic int rate_position(logic [31:0] rate, int n);
        int i;
        for (i = n - 1; i >= 0; i--)
            if (pred_tbl[i] == rate)
                return i;
        return 0;
    endfunction

    // {increase taken, index}: one entry up unless the next one sits
    // above the window; below the window the candidate is taken directly
    function automatic logic [4:0] step_once(int cur, int cand);
        logic [31:0] nxt;
        nxt = pred_tbl[cur+1];
        if (nxt > pred_cfg.rate_max)
            return {1'b0, cur[3:0]};
        if (nxt < pred_cfg.rate_min)
            return {1'b0, cand[3:0]};
        return {1'b1, 4'(cur + 1)};
    endfunction

    function automatic abr_choice_t choose_rate(abr_item_t it);
        abr_choice_t res;
        int          n;
        int          cur;
        int          cand;
        int          sel;
        bit          try_up;
        longint      play;
        longint      since;
        logic [4:0]  st;
        res    = '0;
        n      = used_entries();
        sel    = 0;
        cand   = 0;
        try_up = 1'b0;
        if (it.mode == 1'b0)
        begin
            pred_tbl[it.entry_index] = it.entry_bitrate;
            return res;
        end
        if (pred_cfg.rate_min > pred_cfg.rate_max)
        begin
            res.err = 1'b1;
            return res;
        end
        if (it.last_tp == 32'd0)
        begin
            sel     = lowest_in_window(n);
            res.idx = sel[3:0];
            return res;
        end
        // both differences are signed; negative play time counts as ramp-up
        play  = $signed({32'd0, it.now_s}) - $signed({32'd0, pred_cfg.start_seconds});
        since = $signed({32'd0, it.now_s}) - $signed({32'd0, pred_last_up});
        cur   = rate_position(it.cur_rate, n);
        sel   = cur;
        if (it.buffer_lvl >= pred_cfg.normal_buffer_ms)
        begin
            // high band: avg and last throughput must both allow a higher entry
            cand = best_fit(it.avg_tp, n);
            if (cand > cur)
            begin
                cand = best_fit(it.last_tp, n);
                if (cand > cur &&
                    (since >= $signed({48'd0, pred_cfg.switch_up_hold_s}) ||
                     play < $signed({48'd0, pred_cfg.rampup_s})))
                    try_up = 1'b1;
            end
        end
        else if (it.buffer_lvl >= pred_cfg.low_buffer_ms)
        begin
            cand = best_fit(it.last_tp, n);
            if (cand < cur)
            begin
                if (pred_tbl[cur-1] >= pred_cfg.rate_min)
                    sel = cur - 1;
            end
            else if (cand > cur)
                try_up = 1'b1;
        end
        else
            sel = lowest_in_window(n);
        if (try_up)
        begin
            st  = step_once(cur, cand);
            sel = st[3:0];
            if (st[4])
            begin
                pred_last_up = it.now_s;
                res.up       = 1'b1;
            end
        end
        res.idx = sel[3:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: checks the result strobe, tracks register writes and
    // predicts every accepted item, all at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        abr_choice_t want;
        abr_item_t   seen;
        if (!rst_n)
        begin
            pred_last_up          = '0;
            pred_cfg.rate_min         = abs_pkg::RST_RATE_MIN;
            pred_cfg.rate_max         = abs_pkg::RST_RATE_MAX;
            pred_cfg.table_size       = abs_pkg::RST_TABLE_SIZE;
            pred_cfg.low_buffer_ms    = abs_pkg::RST_LOW_BUFFER;
            pred_cfg.normal_buffer_ms = abs_pkg::RST_NORMAL_BUFFER;
            pred_cfg.switch_up_hold_s = abs_pkg::RST_SWITCH_HOLD;
            pred_cfg.rampup_s         = abs_pkg::RST_RAMPUP;
            pred_cfg.start_seconds    = abs_pkg::RST_START_SECONDS;
        end
        else
        begin
            if (done)
            begin
                if (choice_q.size() == 0)
                begin
                    errors++;
                    $display("%0t ERROR result with no item outstanding: index %0d err %0b up %0b",
                             $time, new_index, range_error, stepped_up);
                end
                else
                begin
                    want = choice_q.pop_front();
                    if (want.idx !== new_index)
                    begin
                        errors++;
                        $display("%0t ERROR new_index expected %0d actual %0d",
                                 $time, want.idx, new_index);
                    end
                    if (want.err !== range_error)
                    begin
                        errors++;
                        $display("%0t ERROR range_error expected %0b actual %0b",
                                 $time, want.err, range_error);
                    end
                    if (want.up !== stepped_up)
                    begin
                        errors++;
                        $display("%0t ERROR stepped_up expected %0b actual %0b",
                                 $time, want.up, stepped_up);
                    end
                    if (want.err)
                        n_range_err++;
                    if (want.up)
                        n_steps++;
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    abs_pkg::REG_RATE_MIN:      pred_cfg.rate_min         = cfg_wdata[30:0];
                    abs_pkg::REG_RATE_MAX:      pred_cfg.rate_max         = cfg_wdata[30:0];
                    abs_pkg::REG_TABLE_SIZE:    pred_cfg.table_size       = cfg_wdata[4:0];
                    abs_pkg::REG_LOW_BUFFER:    pred_cfg.low_buffer_ms    = cfg_wdata[19:0];
                    abs_pkg::REG_NORMAL_BUFFER: pred_cfg.normal_buffer_ms = cfg_wdata[19:0];
                    abs_pkg::REG_SWITCH_HOLD:   pred_cfg.switch_up_hold_s = cfg_wdata[15:0];
                    abs_pkg::REG_RAMPUP:        pred_cfg.rampup_s         = cfg_wdata[15:0];
                    abs_pkg::REG_START_SECONDS: pred_cfg.start_seconds    = cfg_wdata;
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                seen.mode          = mode;
                seen.entry_index   = entry_index;
                seen.entry_bitrate = entry_bitrate;
                seen.last_tp       = last_throughput;
                seen.avg_tp        = avg_throughput;
                seen.buffer_lvl    = buffer_ms;
                seen.cur_rate      = current_bitrate;
                seen.now_s         = now_seconds;
                choice_q.push_back(choose_rate(seen));
                if (mode)
                    n_decisions++;
                else
                    n_loads++;
                taken_cnt++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: presents queued items at the falling edge, holds each one
    // until the monitor has seen it taken, and inserts random idle bursts.
    // ------------------------------------------------------------------
    abr_item_t   item_q [$];
    int unsigned seen_cnt = 0;
    int          gap      = 0;
    int          idle_pct = 20;
    bit          calm     = 1'b0;

    always @(negedge clk)
    begin
        abr_item_t it;
        bit        consumed;
        if (rst_n)
        begin
            consumed = start && (taken_cnt != seen_cnt);
            if (consumed)
            begin
                seen_cnt = taken_cnt;
                if (!calm && $urandom_range(99, 0) < idle_pct)
                    gap = $urandom_range(16, 1);
            end
            if (start && !consumed)
                ;   // block still busy, keep the item on the ports
            else if (gap > 0)
            begin
                gap--;
                start <= 1'b0;
            end
            else if (item_q.size() != 0)
            begin
                it = item_q.pop_front();
                mode            <= it.mode;
                entry_index     <= it.entry_index;
                entry_bitrate   <= it.entry_bitrate;
                last_throughput <= it.last_tp;
                avg_throughput  <= it.avg_tp;
                buffer_ms       <= it.buffer_lvl;
                current_bitrate <= it.cur_rate;
                now_seconds     <= it.now_s;
                start           <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // run limit
    int unsigned cycle_cnt = 0;

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("%0t timeout after %0d cycles", $time, cycle_cnt);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: the generator keeps its own view of the table, registers
    // and the wall clock so that items land near the interesting limits.
    // ------------------------------------------------------------------
    logic [31:0]   gen_tbl [DEPTH];
    abs_pkg::cfg_t gen_cfg;
    logic [31:0]   now_t;

    task automatic push_load(int idx, logic [31:0] val);
        abr_item_t it;
        it               = '0;
        it.mode          = 1'b0;
        it.entry_index   = idx[3:0];
        it.entry_bitrate = val;
        // decision fields are don't-care on loads; keep them moving
        it.last_tp       = $urandom();
        it.avg_tp        = $urandom();
        it.buffer_lvl    = 20'($urandom());
        it.cur_rate      = $urandom();
        it.now_s         = $urandom();
        gen_tbl[idx]     = val;
        item_q.push_back(it);
    endtask

    task automatic push_decide(logic [31:0] ltp, logic [31:0] atp, logic [19:0] lvl,
                               logic [31:0] cur, logic [31:0] nw);
        abr_item_t it;
        it               = '0;
        it.mode          = 1'b1;
        it.entry_index   = 4'($urandom());
        it.entry_bitrate = $urandom();
        it.last_tp       = ltp;
        it.avg_tp        = atp;
        it.buffer_lvl    = lvl;
        it.cur_rate      = cur;
        it.now_s         = nw;
        item_q.push_back(it);
    endtask

    // ascending table with random ratios; sometimes the top entry is above
    // any 31-bit window limit
    task automatic push_ascending_table();
        logic [31:0] v;
        int          i;
        v = $urandom_range(2000000, 1);
        for (i = 0; i < DEPTH; i++)
        begin
            if (i == DEPTH - 1 && $urandom_range(3, 0) == 0)
                v = 32'h8000_0000 | $urandom();
            push_load(i, v);
            v = v + v / $urandom_range(8, 2) + $urandom_range(1000, 1);
        end
    endtask

    // throughput near the fit threshold of some entry (5*b/4 +/- 2), else zero or random
    function automatic logic [31:0] pick_tp();
        logic [63:0] t;
        int          r;
        r = $urandom_range(99, 0);
        if (r < 6)
            return 32'd0;
        if (r < 14)
            return $urandom();
        t = ({32'd0, gen_tbl[$urandom_range(DEPTH - 1, 0)]} * 64'd5) / 64'd4;
        t = t + $urandom_range(4, 0);
        if (t >= 64'd2)
            t = t - 64'd2;
        if (t > 64'hFFFF_FFFF)
            t = 64'hFFFF_FFFF;
        return t[31:0];
    endfunction

    task automatic push_random_decision();
        logic [31:0] cur;
        logic [19:0] lvl;
        int          r;
        now_t = now_t + $urandom_range(6, 0);
        if ($urandom_range(99, 0) < 3)
            now_t = $urandom();   // clock jump, may go backwards
        cur = ($urandom_range(99, 0) < 90) ? gen_tbl[$urandom_range(DEPTH - 1, 0)]
                                           : $urandom();
        r = $urandom_range(99, 0);
        if (r < 10)
            lvl = 20'($urandom());
        else if (r < 35)
            lvl = (gen_cfg.low_buffer_ms != 0)
                  ? 20'($urandom_range(gen_cfg.low_buffer_ms - 1, 0)) : 20'd0;
        else if (r < 65 && gen_cfg.normal_buffer_ms > gen_cfg.low_buffer_ms)
            lvl = 20'($urandom_range(gen_cfg.normal_buffer_ms - 1, gen_cfg.low_buffer_ms));
        else
            lvl = 20'($urandom_range(20'hFFFFF, gen_cfg.normal_buffer_ms));
        push_decide(pick_tp(), pick_tp(), lvl, cur, now_t);
    endtask

    task automatic push_random_items(int count);
        int k;
        int r;
        int idx;
        for (k = 0; k < count; k++)
        begin
            r = $urandom_range(99, 0);
            if (r < 4)
                push_load($urandom_range(DEPTH - 1, 0), $urandom());
            else if (r < 7)
            begin
                idx = $urandom_range(DEPTH - 1, 0);
                push_load(idx, gen_tbl[idx] + $urandom_range(3, 0));
            end
            else
                push_random_decision();
        end
    endtask

    // waits until every item has gone in and every result has come out
    task automatic wait_idle();
        while (item_q.size() != 0 || start || busy || choice_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic write_reg(logic [abs_pkg::CFG_IDX_W-1:0] idx,
                             logic [abs_pkg::DATA_W-1:0] val);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
    endtask

    // all eight registers; bit 31 of the 31-bit ones carries junk
    task automatic apply_cfg(abs_pkg::cfg_t c);
        gen_cfg = c;
        write_reg(abs_pkg::REG_RATE_MIN,      {1'($urandom()), c.rate_min});
        write_reg(abs_pkg::REG_RATE_MAX,      {1'($urandom()), c.rate_max});
        write_reg(abs_pkg::REG_TABLE_SIZE,    {27'd0, c.table_size});
        write_reg(abs_pkg::REG_LOW_BUFFER,    {12'd0, c.low_buffer_ms});
        write_reg(abs_pkg::REG_NORMAL_BUFFER, {12'd0, c.normal_buffer_ms});
        write_reg(abs_pkg::REG_SWITCH_HOLD,   {16'd0, c.switch_up_hold_s});
        write_reg(abs_pkg::REG_RAMPUP,        {16'd0, c.rampup_s});
        write_reg(abs_pkg::REG_START_SECONDS, c.start_seconds);
        @(negedge clk);
        cfg_wr_en = 1'b0;
        n_settings++;
    endtask

    function automatic abs_pkg::cfg_t pick_cfg(int p);
        abs_pkg::cfg_t c;
        int            r;
        logic [30:0]   t;
        c = '0;
        if (p == 0)
        begin
            // inverted window, start time at its ceiling, every other register at its floor
            c.rate_min      = 31'h7FFF_FFFF;
            c.rate_max      = 31'd0;
            c.table_size    = 5'd0;
            c.start_seconds = 32'hFFFF_FFFF;
            return c;
        end
        if (p == 1)
        begin
            // widest window, start time at its floor, every other register at its ceiling
            c.rate_min         = 31'd0;
            c.rate_max         = 31'h7FFF_FFFF;
            c.table_size       = 5'd31;
            c.low_buffer_ms    = 20'hFFFFF;
            c.normal_buffer_ms = 20'hFFFFF;
            c.switch_up_hold_s = 16'hFFFF;
            c.rampup_s         = 16'hFFFF;
            c.start_seconds    = 32'd0;
            return c;
        end
        r = $urandom_range(99, 0);
        if (r < 60)
            c.table_size = 5'd16;
        else if (r < 80)
            c.table_size = 5'($urandom_range(16, 1));
        else if (r < 90)
            c.table_size = 5'd0;
        else
            c.table_size = 5'($urandom_range(31, 17));
        r = $urandom_range(99, 0);
        if (r < 30)
            c.rate_min = 31'd0;
        else if (r < 60)
            c.rate_min = gen_tbl[$urandom_range(DEPTH - 1, 0)][30:0];
        else if (r < 80)
            c.rate_min = gen_tbl[$urandom_range(DEPTH - 1, 0)][30:0] - 31'd1;
        else
            c.rate_min = 31'($urandom());
        r = $urandom_range(99, 0);
        if (r < 30)
            c.rate_max = 31'h7FFF_FFFF;
        else if (r < 60)
            c.rate_max = gen_tbl[$urandom_range(DEPTH - 1, 0)][30:0];
        else if (r < 80)
            c.rate_max = gen_tbl[$urandom_range(DEPTH - 1, 0)][30:0] + 31'd1;
        else
            c.rate_max = 31'($urandom());
        // keep most windows upright; a few stay inverted
        if (c.rate_min > c.rate_max && $urandom_range(99, 0) < 85)
        begin
            t          = c.rate_min;
            c.rate_min = c.rate_max;
            c.rate_max = t;
        end
        c.low_buffer_ms = 20'($urandom_range(30000, 0));
        if ($urandom_range(99, 0) < 10)
            c.normal_buffer_ms = 20'($urandom_range(c.low_buffer_ms, 0));
        else
            c.normal_buffer_ms = 20'(c.low_buffer_ms + $urandom_range(30000, 0));
        c.switch_up_hold_s = ($urandom_range(99, 0) < 70) ? 16'($urandom_range(30, 0))
                                                          : 16'($urandom());
        c.rampup_s         = ($urandom_range(99, 0) < 70) ? 16'($urandom_range(40, 0))
                                                          : 16'($urandom());
        r = $urandom_range(99, 0);
        if (r < 50)
            c.start_seconds = now_t - $urandom_range(30, 0);
        else if (r < 75)
            c.start_seconds = now_t + $urandom_range(20, 0);   // playback "not started yet"
        else if (r < 85)
            c.start_seconds = 32'd0;
        else
            c.start_seconds = $urandom();
        return c;
    endfunction

    initial
    begin
        int i;
        int p;
        gen_cfg.rate_min         = abs_pkg::RST_RATE_MIN;
        gen_cfg.rate_max         = abs_pkg::RST_RATE_MAX;
        gen_cfg.table_size       = abs_pkg::RST_TABLE_SIZE;
        gen_cfg.low_buffer_ms    = abs_pkg::RST_LOW_BUFFER;
        gen_cfg.normal_buffer_ms = abs_pkg::RST_NORMAL_BUFFER;
        gen_cfg.switch_up_hold_s = abs_pkg::RST_SWITCH_HOLD;
        gen_cfg.rampup_s         = abs_pkg::RST_RAMPUP;
        gen_cfg.start_seconds    = abs_pkg::RST_START_SECONDS;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at reset settings. Whole table first so no decision
        // ever reads an entry that was never written; 0 and all-ones at the ends.
        push_load(0, 32'd0);
        for (i = 1; i < DEPTH - 1; i++)
            push_load(i, i * 250000);
        push_load(DEPTH - 1, 32'hFFFF_FFFF);
        // zero last throughput: lowest entry in the window
        push_decide(32'd0, 32'd1000000, 20'd30000, 32'd750000, 32'd1);
        // panic band
        push_decide(32'd1000000, 32'd1000000, 20'd0, 32'd750000, 32'd2);
        // middle band, one step up (hold timer restarts)
        push_decide(32'd2000000, 32'd2000000, 20'd10000, 32'd500000, 32'd5);
        // middle band, one step down
        push_decide(32'd1000000, 32'd1000000, 20'd10000, 32'd2000000, 32'd6);
        // high band inside ramp-up, all-ones throughput and buffer
        push_decide(32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF, 32'd1000000, 32'd18);
        // high band after ramp-up with the hold not yet elapsed
        push_decide(32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'd20000, 32'd1250000, 32'd25);
        // playing rate not in the table
        push_decide(32'd500000, 32'd500000, 20'd10000, 32'd12345, 32'd26);
        // nothing fits the throughput
        push_decide(32'd1, 32'd1, 20'd10000, 32'd1250000, 32'd27);
        // band edges: exactly the low mark, then one below it
        push_decide(32'd1000000, 32'd0, 20'd5000, 32'd750000, 32'd28);
        push_decide(32'd1000000, 32'd1000000, 20'd4999, 32'd750000, 32'd29);
        // top of the window, already at the best fitting entry
        push_decide(32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'd19999, 32'd3500000, 32'd40);
        now_t = 32'd40;

        push_random_items(150);
        wait_idle();

        for (p = 0; p < PHASES; p++)
        begin
            apply_cfg(pick_cfg(p));
            if (p == PHASES - 1)
                calm = 1'b1;   // back-to-back items to finish
            else
                case ($urandom_range(2, 0))
                    0:       idle_pct = 0;
                    1:       idle_pct = 15;
                    default: idle_pct = 50;
                endcase
            if (p > 0 && $urandom_range(1, 0) == 1)
                push_ascending_table();
            push_random_items((p == 0) ? 40 : 190);
            wait_idle();
        end

        if (choice_q.size() != 0)
        begin
            errors++;
            $display("%0t ERROR %0d results never arrived", $time, choice_q.size());
        end
        $display("Ran %0d table loads and %0d rate decisions over %0d register settings",
                 n_loads, n_decisions, n_settings);
        $display("  %0d one-step increases, %0d inverted-window results, %0d check errors",
                 n_steps, n_range_err, errors);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
